>>> rtl/pfba_pkg.sv
// pfba_pkg: shared constants, payload structs and control structs for the
// page frame bitmap allocator; no dependencies
package pfba_pkg;

  localparam int FRAME_COUNT = 32768;
  localparam int PAGE_SHIFT  = 12;
  localparam int MAP_BYTES   = (FRAME_COUNT + 7) / 8;
  localparam int MAP_AW      = $clog2(MAP_BYTES);
  localparam int MAP_CW      = MAP_AW + 1;
  localparam int FMIN_W      = 33 - PAGE_SHIFT;
  localparam int FMAX_W      = 32 - PAGE_SHIFT;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONE       = 2'd1;
  localparam logic [1:0] ST_MISALIGNED = 2'd2;
  localparam logic [1:0] ST_RANGE      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ADDRESS = 2'd1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic scan_rd;
    logic free_rd;
    logic wr_alloc;
    logic wr_free;
    logic res_none;
    logic res_bad;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic win_empty;
    logic free_bad;
    logic hit;
    logic last;
    logic more;
  } sts_t;

endpackage

>>> rtl/pfba_datapath.sv
// pfba_datapath: config registers, bitmap memory, scan pointer and result registers
// depends on pfba_pkg; driven by pfba_ctrl commands
module pfba_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pfba_pkg::in_t                  in_item,
  input  logic                           cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  pfba_pkg::cmd_t                 cmd,
  output pfba_pkg::sts_t                 sts,
  output pfba_pkg::out_t                 out_item
);

  logic [7:0] mem [pfba_pkg::MAP_BYTES];

  logic [31:0]                 low_address;
  logic [31:0]                 high_address;
  logic [31:0]                 addr_q;
  logic [pfba_pkg::MAP_CW-1:0] ptr;
  logic [pfba_pkg::MAP_AW-1:0] rd_addr_q;
  logic                        rd_vld;
  logic [7:0]                  rdata;
  logic [pfba_pkg::MAP_AW-1:0] clr_cnt;
  pfba_pkg::out_t              res_q;

  logic [32:0]                   low_sum;
  logic [pfba_pkg::FMIN_W-1:0]   fmin;
  logic [pfba_pkg::FMIN_W-4:0]   win_start;
  logic [pfba_pkg::FMAX_W-1:0]   fmax;
  logic [pfba_pkg::FMAX_W-4:0]   e_raw;
  logic [pfba_pkg::FMAX_W-4:0]   e_adj;
  logic [pfba_pkg::MAP_CW-1:0]   win_end;
  logic [pfba_pkg::MAP_CW-1:0]   end_m1;
  logic [pfba_pkg::FMAX_W-1:0]   free_frame;
  logic [pfba_pkg::MAP_AW-1:0]   free_byte;
  logic [2:0]                    free_bit;
  logic                          misaligned;
  logic                          out_of_range;
  logic [2:0]                    zero_idx;
  logic [pfba_pkg::MAP_AW+2:0]   alloc_frame;
  logic                          mem_we;
  logic [pfba_pkg::MAP_AW-1:0]   mem_waddr;
  logic [7:0]                    mem_wdata;
  logic                          mem_re;
  logic [pfba_pkg::MAP_AW-1:0]   mem_raddr;

  // allocation window in bitmap bytes
  always_comb begin
    low_sum   = 33'(low_address) + 33'((33'd1 << pfba_pkg::PAGE_SHIFT) - 33'd1);
    fmin      = low_sum[32:pfba_pkg::PAGE_SHIFT];
    win_start = fmin[pfba_pkg::FMIN_W-1:3] + (pfba_pkg::FMIN_W-3)'(|fmin[2:0]);
    fmax      = high_address[31:pfba_pkg::PAGE_SHIFT];
    e_raw     = fmax[pfba_pkg::FMAX_W-1:3];
    if ((|fmax[2:0]) && (e_raw != '0)) begin
      e_adj = e_raw - (pfba_pkg::FMAX_W-3)'(1);
    end else begin
      e_adj = e_raw;
    end
    if (32'(e_adj) > 32'(pfba_pkg::MAP_BYTES)) begin
      win_end = pfba_pkg::MAP_CW'(pfba_pkg::MAP_BYTES);
    end else begin
      win_end = pfba_pkg::MAP_CW'(e_adj);
    end
    end_m1 = win_end - pfba_pkg::MAP_CW'(1);
  end

  // free request decode
  always_comb begin
    free_frame   = addr_q[31:pfba_pkg::PAGE_SHIFT];
    free_byte    = free_frame[pfba_pkg::MAP_AW+2:3];
    free_bit     = free_frame[2:0];
    misaligned   = addr_q[pfba_pkg::PAGE_SHIFT-1:0] != '0;
    out_of_range = 32'(free_frame) >= 32'(pfba_pkg::FRAME_COUNT);
  end

  // lowest clear bit of the byte under test
  always_comb begin
    zero_idx = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!rdata[j]) begin
        zero_idx = 3'(j);
      end
    end
    alloc_frame = {rd_addr_q, zero_idx};
  end

  always_comb begin
    mem_we    = cmd.clr_wr || cmd.wr_alloc || cmd.wr_free;
    mem_waddr = clr_cnt;
    mem_wdata = 8'h00;
    if (cmd.wr_alloc) begin
      mem_waddr = rd_addr_q;
      mem_wdata = rdata | (8'd1 << zero_idx);
    end else if (cmd.wr_free) begin
      mem_waddr = free_byte;
      mem_wdata = rdata & ~(8'd1 << free_bit);
    end
    mem_re    = cmd.scan_rd || cmd.free_rd;
    mem_raddr = cmd.scan_rd ? ptr[pfba_pkg::MAP_AW-1:0] : free_byte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_address  <= '0;
      high_address <= '0;
      clr_cnt      <= '0;
      rd_vld       <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == pfba_pkg::CFG_LOW_ADDRESS)) begin
        low_address <= cfg_data;
      end
      if (cfg_we && (cfg_index == pfba_pkg::CFG_HIGH_ADDRESS)) begin
        high_address <= cfg_data;
      end
      if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + pfba_pkg::MAP_AW'(1);
      end
      rd_vld <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      addr_q             <= in_item.address;
      ptr                <= pfba_pkg::MAP_CW'(win_start);
      res_q.page_address <= '0;
      res_q.status       <= cmd.res_none ? pfba_pkg::ST_NONE : pfba_pkg::ST_OK;
    end
    if (cmd.scan_rd) begin
      ptr       <= ptr + pfba_pkg::MAP_CW'(1);
      rd_addr_q <= ptr[pfba_pkg::MAP_AW-1:0];
    end
    if (cmd.res_none && !cmd.take) begin
      res_q.status <= pfba_pkg::ST_NONE;
    end
    if (cmd.res_bad) begin
      res_q.status <= misaligned ? pfba_pkg::ST_MISALIGNED : pfba_pkg::ST_RANGE;
    end
    if (cmd.wr_alloc) begin
      res_q.page_address <= 32'({alloc_frame, {pfba_pkg::PAGE_SHIFT{1'b0}}});
    end
    if (cmd.out_load) begin
      out_item <= res_q;
    end
  end

  always_comb begin
    sts.clr_done  = clr_cnt == pfba_pkg::MAP_AW'(pfba_pkg::MAP_BYTES - 1);
    sts.win_empty = 32'(win_start) >= 32'(win_end);
    sts.free_bad  = misaligned || out_of_range;
    sts.hit       = rd_vld && (rdata != pfba_pkg::FULL_BYTE);
    sts.last      = rd_vld && ({1'b0, rd_addr_q} == end_m1);
    sts.more      = ptr < win_end;
  end

endmodule

>>> rtl/pfba_ctrl.sv
// pfba_ctrl: sequencer for bitmap clear, first-fit scan and free
// depends on pfba_pkg; commands pfba_datapath
module pfba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_opcode,
  input  logic           out_ready,
  input  pfba_pkg::sts_t sts,
  output logic           in_ready,
  output logic           out_valid,
  output pfba_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_FREE_CHK = 3'd3;
  localparam logic [2:0] S_FREE_WR  = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_xfer;

  assign in_ready = state == S_IDLE;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd.take = 1'b1;
          if (in_opcode == pfba_pkg::OP_FREE) begin
            state_next = S_FREE_CHK;
          end else if (sts.win_empty) begin
            cmd.res_none = 1'b1;
            state_next   = S_RESP;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.wr_alloc = 1'b1;
          state_next   = S_RESP;
        end else if (sts.last) begin
          cmd.res_none = 1'b1;
          state_next   = S_RESP;
        end else if (sts.more) begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_FREE_CHK: begin
        if (sts.free_bad) begin
          cmd.res_bad = 1'b1;
          state_next  = S_RESP;
        end else begin
          cmd.free_rd = 1'b1;
          state_next  = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        cmd.wr_free = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_alloc_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_alloc |-> (state == S_SCAN) && sts.hit)
    else $error("allocation write without a free bit found");

  a_scan_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> sts.more && !sts.win_empty)
    else $error("scan read outside the window");

  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> (state == S_CLEAR) || (state == S_IDLE))
    else $error("clear pass left to a busy state");

endmodule

>>> rtl/page_frame_bitmap_allocator.sv
// page_frame_bitmap_allocator: first-fit page frame allocator over a 4096-byte bitmap
// after a synchronous reset a clearing pass zeroes the bitmap; no item is taken during it
// allocate: result after a scan of n bytes (1 to 4096, one a cycle), or direct from idle if the
// window is empty; free: check, byte read, byte write, or only the check if misaligned/out of range
// one item in flight; next transfer in the cycle after the result loads, which waits on a held result
// depends on pfba_pkg, pfba_ctrl, pfba_datapath
module page_frame_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pfba_pkg::in_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pfba_pkg::out_t                 out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  pfba_pkg::cmd_t cmd;
  pfba_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pfba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_item.opcode),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pfba_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule
